@@ rtl/music_frame_command_parser_unit_macros.svh @@
// assertion helpers for the rtl
`ifndef MUSIC_FRAME_COMMAND_PARSER_UNIT_MACROS_SVH
`define MUSIC_FRAME_COMMAND_PARSER_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define MFCP_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define MFCP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MFCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mfcp_pkg.sv @@
`default_nettype none

package mfcp_pkg;

    // result kinds
    localparam logic [3:0] KIND_PSG     = 4'd0;
    localparam logic [3:0] KIND_YM0     = 4'd1;
    localparam logic [3:0] KIND_YM1     = 4'd2;
    localparam logic [3:0] KIND_KEY     = 4'd3;
    localparam logic [3:0] KIND_EXTRA   = 4'd4;
    localparam logic [3:0] KIND_NORMAL  = 4'd5;
    localparam logic [3:0] KIND_LOOP    = 4'd6;
    localparam logic [3:0] KIND_END     = 4'd7;
    localparam logic [3:0] KIND_OVERRUN = 4'd8;

    // payload kinds
    localparam logic [2:0] PK_PSG    = 3'd0;
    localparam logic [2:0] PK_YM0    = 3'd1;
    localparam logic [2:0] PK_YM1    = 3'd2;
    localparam logic [2:0] PK_KEY    = 3'd3;
    localparam logic [2:0] PK_SKIP   = 3'd4;
    localparam logic [2:0] PK_OFFSET = 3'd5;

    // command groups, upper three bits of the shifted command
    localparam logic [2:0] GRP_MISC   = 3'h0;
    localparam logic [2:0] GRP_PSG    = 3'h1;
    localparam logic [2:0] GRP_YM0    = 3'h2;
    localparam logic [2:0] GRP_YM1    = 3'h3;
    localparam logic [2:0] GRP_KEY    = 3'h4;
    localparam logic [2:0] GRP_YMST   = 3'h5;
    localparam logic [2:0] GRP_PCM    = 3'h6;
    localparam logic [2:0] GRP_SYS    = 3'h7;

    localparam logic [6:0] CMD_EXTRA  = 7'h7D;
    localparam logic [6:0] CMD_LOOP   = 7'h7E;
    localparam logic [6:0] CMD_END    = 7'h7F;

    localparam logic [5:0] LOOP_PAYLOAD_LEN = 6'd3;

    localparam int RESULT_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_SIZE    = 2'd0,
        PH_CMD     = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  data_byte;
        logic [23:0] frame_value;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [5:0] size;
        logic [2:0] pkind;
        logic       is_extra;
        logic       is_loop;
        logic       is_end;
    } cmd_info_t;

    function automatic result_t make_result(input logic [3:0] kind,
                                            input logic [7:0] data,
                                            input logic [23:0] value);
        result_t r;
        r.kind        = kind;
        r.data_byte   = data;
        r.frame_value = value;
        r.last        = 1'b0;
        return r;
    endfunction

    // frame close status: loop beats end beats normal
    function automatic result_t close_result(input logic [23:0] loop_ofs,
                                             input logic        end_flag,
                                             input logic [7:0]  total);
        result_t r;
        if (loop_ofs != 24'd0) begin
            r = make_result(KIND_LOOP, 8'd0, loop_ofs);
        end else if (end_flag) begin
            r = make_result(KIND_END, 8'd0, 24'd0);
        end else begin
            r = make_result(KIND_NORMAL, 8'd0, {16'd0, total});
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mfcp_cmd_decode.sv @@
`default_nettype none

module mfcp_cmd_decode (
    input  wire logic [7:0]          cmd_byte,
    output mfcp_pkg::cmd_info_t      info
);
    import mfcp_pkg::*;

    logic [6:0] c;

    assign c = cmd_byte[7:1];

    always_comb begin
        info.size     = 6'd0;
        info.pkind    = PK_SKIP;
        info.is_extra = 1'b0;
        info.is_loop  = 1'b0;
        info.is_end   = 1'b0;
        unique case (c[6:4])
            GRP_PSG: begin
                info.pkind = PK_PSG;
                info.size  = c[3] ? ({4'd0, c[1:0]} + 6'd1) : ({3'd0, c[2:0]} + 6'd1);
            end
            GRP_YM0: begin
                info.pkind = PK_YM0;
                info.size  = {({1'b0, c[3:0]} + 5'd1), 1'b0};
            end
            GRP_YM1: begin
                info.pkind = PK_YM1;
                info.size  = {({1'b0, c[3:0]} + 5'd1), 1'b0};
            end
            GRP_KEY: begin
                info.pkind = PK_KEY;
                info.size  = {2'd0, c[3:0]} + 6'd1;
            end
            GRP_YMST: begin
                info.size = 6'd1;
            end
            GRP_PCM: begin
                info.size = {({1'b0, c[3:0]} + 5'd1), 1'b0};
            end
            GRP_SYS: begin
                // only the top three codes of this group do anything
                if (c == CMD_EXTRA) begin
                    info.is_extra = 1'b1;
                end else if (c == CMD_LOOP) begin
                    info.size    = LOOP_PAYLOAD_LEN;
                    info.pkind   = PK_OFFSET;
                    info.is_loop = 1'b1;
                end else if (c == CMD_END) begin
                    info.is_end = 1'b1;
                end
            end
            GRP_MISC: begin
                info.size = 6'd0;
            end
            default: begin
                info.size = 6'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/mfcp_result_queue.sv @@
`default_nettype none

`include "music_frame_command_parser_unit_macros.svh"

module mfcp_result_queue #(
    parameter int Depth = mfcp_pkg::RESULT_QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [1:0]        push_n,
    input  mfcp_pkg::result_t      push_a,
    input  mfcp_pkg::result_t      push_b,
    output logic                   room_two,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mfcp_pkg::result_t      out_data
);
    import mfcp_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    result_t           mem_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              pop;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    assign room_two     = (count_reg <= CntW'(Depth - 2));
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push_n == 2'd1) begin
            wr_ptr_next = wr_ptr_plus1;
        end else if (push_n == 2'd2) begin
            wr_ptr_next = ptr_inc(wr_ptr_plus1);
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push_n) - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push_b;
        end
    end

    `MFCP_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CntW'(Depth), "queue count exceeds depth")
    `MFCP_ASSERT_SAME(a_empty_ptrs, aclk, aresetn, count_reg == '0, rd_ptr_reg == wr_ptr_reg, "empty queue with unequal pointers")
    `MFCP_ASSERT_NEXT(a_pair_push, aclk, aresetn, (push_n == 2'd2) && !pop, count_reg == $past(count_reg) + CntW'(2), "pair push lost an entry")

endmodule

`default_nettype wire

@@ rtl/music_frame_command_parser_unit.sv @@
// results of an accepted byte are registered in the result queue and leave in order
// throughput: one byte per cycle while s_ready is high; two results leave in turn
// s_ready drops while the result queue has fewer than two free slots
// reset: synchronous active-low aresetn returns to waiting for a frame size byte,
// clears all counters, loop offset and end flag, and empties the result queue
`default_nettype none

module music_frame_command_parser_unit #(
    parameter int QueueDepth = mfcp_pkg::RESULT_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_stream_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_kind,
    output logic [7:0]       m_data_byte,
    output logic [23:0]      m_frame_value,
    output logic             m_last
);
    import mfcp_pkg::*;

    // parser state
    phase_t       phase_reg, phase_next;
    logic [7:0]   frame_left_reg, frame_left_next;
    logic [5:0]   payload_left_reg, payload_left_next;
    logic [2:0]   payload_kind_reg, payload_kind_next;
    logic [7:0]   frame_total_reg, frame_total_next;
    logic [23:0]  loop_offset_reg, loop_offset_next;
    logic [1:0]   offset_idx_reg, offset_idx_next;
    logic         end_seen_reg, end_seen_next;

    // decode and shared decisions
    cmd_info_t    info;
    logic         accept;
    logic [7:0]   fl_dec;
    logic [7:0]   size_ext;
    logic         cmd_overrun;
    logic [7:0]   fl_after_cmd;
    logic         cmd_close;
    logic         end_after_cmd;
    logic [5:0]   pl_dec;
    logic [23:0]  loop_after_pay;
    logic         pay_close;

    // results of this request: up to two, a before b
    result_t      res_a, res_b, push_a;
    logic         res_a_v, res_b_v;
    logic [1:0]   push_n;
    logic         room_two;
    result_t      out_data;

    assign accept = s_valid && s_ready;
    assign s_ready = room_two;

    mfcp_cmd_decode u_decode (
        .cmd_byte (s_stream_byte),
        .info     (info)
    );

    // decisions used by both the state update and the result build
    always_comb begin
        fl_dec        = frame_left_reg - 8'd1;
        size_ext      = {2'd0, info.size};
        cmd_overrun   = (size_ext > fl_dec);
        fl_after_cmd  = fl_dec - size_ext;
        cmd_close     = !cmd_overrun && (info.size == 6'd0) && (fl_after_cmd == 8'd0);
        end_after_cmd = end_seen_reg | info.is_end;
        pl_dec        = payload_left_reg - 6'd1;
        pay_close     = (pl_dec == 6'd0) && (frame_left_reg == 8'd0);

        // little-endian loop offset assembly
        loop_after_pay = loop_offset_reg;
        if (payload_kind_reg == PK_OFFSET) begin
            unique case (offset_idx_reg)
                2'd0:    loop_after_pay = {16'd0, s_stream_byte};
                2'd1:    loop_after_pay = loop_offset_reg | {8'd0, s_stream_byte, 8'd0};
                default: loop_after_pay = loop_offset_reg | {s_stream_byte, 16'd0};
            endcase
        end
    end

    // next state
    always_comb begin
        phase_next        = phase_reg;
        frame_left_next   = frame_left_reg;
        payload_left_next = payload_left_reg;
        payload_kind_next = payload_kind_reg;
        frame_total_next  = frame_total_reg;
        loop_offset_next  = loop_offset_reg;
        offset_idx_next   = offset_idx_reg;
        end_seen_next     = end_seen_reg;

        if (accept) begin
            unique case (phase_reg)
                PH_CMD: begin
                    end_seen_next = end_after_cmd;
                    if (info.is_loop) begin
                        offset_idx_next = 2'd0;
                    end
                    if (cmd_overrun) begin
                        // payload runs past the frame: drop it
                        frame_left_next   = fl_dec;
                        phase_next        = PH_SIZE;
                        payload_left_next = 6'd0;
                        loop_offset_next  = 24'd0;
                        end_seen_next     = 1'b0;
                        offset_idx_next   = 2'd0;
                    end else begin
                        frame_left_next = fl_after_cmd;
                        if (info.size != 6'd0) begin
                            payload_left_next = info.size;
                            payload_kind_next = info.pkind;
                            phase_next        = PH_PAYLOAD;
                        end else if (cmd_close) begin
                            phase_next       = PH_SIZE;
                            loop_offset_next = 24'd0;
                            end_seen_next    = 1'b0;
                            offset_idx_next  = 2'd0;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    loop_offset_next  = loop_after_pay;
                    if (payload_kind_reg == PK_OFFSET) begin
                        offset_idx_next = offset_idx_reg + 2'd1;
                    end
                    payload_left_next = pl_dec;
                    if (pl_dec == 6'd0) begin
                        phase_next = PH_CMD;
                        if (frame_left_reg == 8'd0) begin
                            phase_next       = PH_SIZE;
                            loop_offset_next = 24'd0;
                            end_seen_next    = 1'b0;
                            offset_idx_next  = 2'd0;
                        end
                    end
                end
                default: begin
                    // size byte, also taken for the unused phase code
                    frame_total_next  = s_stream_byte;
                    loop_offset_next  = 24'd0;
                    end_seen_next     = 1'b0;
                    offset_idx_next   = 2'd0;
                    payload_left_next = 6'd0;
                    if (s_stream_byte == 8'd0) begin
                        phase_next      = PH_SIZE;
                        frame_left_next = 8'd0;
                    end else begin
                        frame_left_next = s_stream_byte - 8'd1;
                        // a size of one is an empty frame that closes at once
                        phase_next      = (s_stream_byte == 8'd1) ? PH_SIZE : PH_CMD;
                    end
                end
            endcase
        end
    end

    // results
    always_comb begin
        res_a   = make_result(KIND_EXTRA, 8'd0, 24'd0);
        res_b   = make_result(KIND_OVERRUN, 8'd0, 24'd0);
        res_a_v = 1'b0;
        res_b_v = 1'b0;

        unique case (phase_reg)
            PH_CMD: begin
                res_a_v = info.is_extra;
                if (cmd_overrun) begin
                    res_b_v = 1'b1;
                end else if (cmd_close) begin
                    res_b   = close_result(loop_offset_reg, end_after_cmd, frame_total_reg);
                    res_b_v = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                if (payload_kind_reg <= PK_KEY) begin
                    res_a   = make_result({1'b0, payload_kind_reg}, s_stream_byte, 24'd0);
                    res_a_v = 1'b1;
                end
                if (pay_close) begin
                    res_b   = close_result(loop_after_pay, end_seen_reg, frame_total_reg);
                    res_b_v = 1'b1;
                end
            end
            default: begin
                if (s_stream_byte == 8'd0) begin
                    res_b_v = 1'b1;
                end else if (s_stream_byte == 8'd1) begin
                    res_b   = close_result(24'd0, 1'b0, s_stream_byte);
                    res_b_v = 1'b1;
                end
            end
        endcase

        // the final result of the request carries last
        res_b.last = 1'b1;
        res_a.last = !res_b_v;

        push_a = res_a_v ? res_a : res_b;
        push_n = accept ? ({1'b0, res_a_v} + {1'b0, res_b_v}) : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SIZE;
            frame_left_reg   <= 8'd0;
            payload_left_reg <= 6'd0;
            payload_kind_reg <= PK_PSG;
            frame_total_reg  <= 8'd0;
            loop_offset_reg  <= 24'd0;
            offset_idx_reg   <= 2'd0;
            end_seen_reg     <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            frame_left_reg   <= frame_left_next;
            payload_left_reg <= payload_left_next;
            payload_kind_reg <= payload_kind_next;
            frame_total_reg  <= frame_total_next;
            loop_offset_reg  <= loop_offset_next;
            offset_idx_reg   <= offset_idx_next;
            end_seen_reg     <= end_seen_next;
        end
    end

    // queue parts the two sides; input flows while results wait, given two free slots
    mfcp_result_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push_a    (push_a),
        .push_b    (res_b),
        .room_two  (room_two),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_kind        = out_data.kind;
    assign m_data_byte   = out_data.data_byte;
    assign m_frame_value = out_data.frame_value;
    assign m_last        = out_data.last;

endmodule

`default_nettype wire

@@ bench/mfcp_stream_checker.sv @@
module mfcp_stream_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [7:0]  s_stream_byte,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [3:0]  m_kind,
    input  wire logic [7:0]  m_data_byte,
    input  wire logic [23:0] m_frame_value,
    input  wire logic        m_last,
    output int               fail_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import mfcp_pkg::*;

    // parser state as seen from the stream
    phase_t      phase;
    logic [7:0]  frm_left;
    logic [5:0]  pay_left;
    logic [2:0]  pay_kind;
    logic [7:0]  frm_total;
    logic [23:0] loop_ofs;
    logic [1:0]  ofs_idx;
    logic        end_flag;

    result_t     expected_results[$];
    int          errors;

    initial begin
        errors = 0;
    end

    function automatic result_t status_result(input logic [3:0] kind, input logic [7:0] data,
                                              input logic [23:0] value);
        result_t r;
        r.kind        = kind;
        r.data_byte   = data;
        r.frame_value = value;
        r.last        = 1'b0;
        return r;
    endfunction

    task automatic clear_parser();
        phase     = PH_SIZE;
        frm_left  = '0;
        pay_left  = '0;
        pay_kind  = '0;
        frm_total = '0;
        loop_ofs  = '0;
        ofs_idx   = '0;
        end_flag  = 1'b0;
    endtask

    // loop offset wins over end, end wins over normal
    task automatic close_frame_status();
        if (loop_ofs != 24'd0) begin
            expected_results.push_back(status_result(KIND_LOOP, 8'd0, loop_ofs));
        end else if (end_flag) begin
            expected_results.push_back(status_result(KIND_END, 8'd0, 24'd0));
        end else begin
            expected_results.push_back(status_result(KIND_NORMAL, 8'd0, {16'd0, frm_total}));
        end
        phase    = PH_SIZE;
        loop_ofs = '0;
        end_flag = 1'b0;
        ofs_idx  = '0;
    endtask

    task automatic parse_stream_byte(input logic [7:0] b);
        int          n_before;
        logic [6:0]  c;
        int unsigned plen;
        logic [2:0]  pk;
        result_t     tail;
        n_before = expected_results.size();
        if (phase == PH_CMD) begin
            c    = b[7:1];
            plen = 0;
            pk   = PK_SKIP;
            frm_left = frm_left - 8'd1;
            case (c[6:4])
                GRP_PSG: begin
                    plen = c[3] ? int'(c[1:0]) + 1 : int'(c[2:0]) + 1;
                    pk   = PK_PSG;
                end
                GRP_YM0: begin
                    plen = (int'(c[3:0]) + 1) * 2;
                    pk   = PK_YM0;
                end
                GRP_YM1: begin
                    plen = (int'(c[3:0]) + 1) * 2;
                    pk   = PK_YM1;
                end
                GRP_KEY: begin
                    plen = int'(c[3:0]) + 1;
                    pk   = PK_KEY;
                end
                GRP_YMST: plen = 1;
                GRP_PCM:  plen = (int'(c[3:0]) + 1) * 2;
                GRP_SYS: begin
                    if (c == CMD_EXTRA) begin
                        expected_results.push_back(status_result(KIND_EXTRA, 8'd0, 24'd0));
                    end else if (c == CMD_LOOP) begin
                        plen    = 3;
                        pk      = PK_OFFSET;
                        ofs_idx = '0;
                    end else if (c == CMD_END) begin
                        end_flag = 1'b1;
                    end
                end
                default: ;
            endcase
            if (plen > frm_left) begin
                expected_results.push_back(status_result(KIND_OVERRUN, 8'd0, 24'd0));
                phase    = PH_SIZE;
                pay_left = '0;
                loop_ofs = '0;
                end_flag = 1'b0;
                ofs_idx  = '0;
            end else begin
                frm_left = frm_left - 8'(plen);
                if (plen > 0) begin
                    pay_left = 6'(plen);
                    pay_kind = pk;
                    phase    = PH_PAYLOAD;
                end else if (frm_left == 8'd0) begin
                    close_frame_status();
                end
            end
        end else if (phase == PH_PAYLOAD) begin
            if (pay_kind <= PK_KEY) begin
                expected_results.push_back(status_result({1'b0, pay_kind}, b, 24'd0));
            end else if (pay_kind == PK_OFFSET) begin
                if (ofs_idx == 2'd0) begin
                    loop_ofs = {16'd0, b};
                end else if (ofs_idx == 2'd1) begin
                    loop_ofs = loop_ofs | {8'd0, b, 8'd0};
                end else begin
                    loop_ofs = loop_ofs | {b, 16'd0};
                end
                ofs_idx = ofs_idx + 2'd1;
            end
            pay_left = pay_left - 6'd1;
            if (pay_left == 6'd0) begin
                phase = PH_CMD;
                if (frm_left == 8'd0) begin
                    close_frame_status();
                end
            end
        end else begin
            frm_total = b;
            loop_ofs  = '0;
            end_flag  = 1'b0;
            ofs_idx   = '0;
            pay_left  = '0;
            if (b == 8'd0) begin
                expected_results.push_back(status_result(KIND_OVERRUN, 8'd0, 24'd0));
                phase    = PH_SIZE;
                frm_left = '0;
            end else begin
                frm_left = b - 8'd1;
                phase    = PH_CMD;
                if (frm_left == 8'd0) begin
                    close_frame_status();
                end
            end
        end
        // the final result of this byte carries last
        if (expected_results.size() > n_before) begin
            tail      = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            clear_parser();
            expected_results.delete();
        end else begin
            // results first, so a stray result is never matched to this edge's request
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: unexpected result kind=%0d data=%02h value=%06h last=%0b",
                                 $realtime, m_kind, m_data_byte, m_frame_value, m_last);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_kind !== want.kind || m_data_byte !== want.data_byte ||
                        m_frame_value !== want.frame_value || m_last !== want.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $write("%0t: mismatch exp kind=%0d data=%02h value=%06h last=%0b",
                                   $realtime, want.kind, want.data_byte, want.frame_value,
                                   want.last);
                            $display(" got kind=%0d data=%02h value=%06h last=%0b",
                                     m_kind, m_data_byte, m_frame_value, m_last);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_stream_byte(s_stream_byte);
            end
        end
        fail_count  <= errors;
        outstanding <= expected_results.size();
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfcp_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_stream_byte;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [23:0] m_frame_value;
    logic        m_last;

    int          fail_count;
    int          outstanding;

    // requests sent so far, and the switch that turns idling off near the end
    int          bytes_sent;
    bit          idling_on;

    // frame body under construction
    logic [7:0]  frame_body[$];

    music_frame_command_parser_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_frame_value (m_frame_value),
        .m_last        (m_last)
    );

    // predicts every accepted request and scores every accepted result
    mfcp_stream_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_stream_byte (s_stream_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_frame_value (m_frame_value),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #20ms;
        $display("FAIL music_frame_command_parser_unit");
        $finish;
    end

    // result side back-pressure: random stall bursts of random length,
    // held off entirely once the quiet tail of the run starts
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // hand one byte to the parser; may open a gap first, then holds valid
    // and the byte steady until the request is taken at a rising edge
    task automatic push_byte(input logic [7:0] b);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        bytes_sent++;
        // last part of the run goes without idling
        if (bytes_sent >= 1700) begin
            idling_on = 1'b0;
        end
    endtask

    function automatic logic [7:0] cmd_byte(input logic [2:0] grp, input logic [3:0] low,
                                            input logic lsb);
        return {grp, low, lsb};
    endfunction

    // how many payload bytes a command byte pulls in (stimulus side only)
    function automatic int payload_len_of(input logic [7:0] b);
        logic [6:0] c;
        c = b[7:1];
        case (c[6:4])
            GRP_PSG:  return c[3] ? int'(c[1:0]) + 1 : int'(c[2:0]) + 1;
            GRP_YM0,
            GRP_YM1,
            GRP_PCM:  return (int'(c[3:0]) + 1) * 2;
            GRP_KEY:  return int'(c[3:0]) + 1;
            GRP_YMST: return 1;
            GRP_SYS:  return (c == CMD_LOOP) ? 3 : 0;
            default:  return 0;
        endcase
    endfunction

    // payload byte with the extremes well represented
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // any command; the system group leans toward extra, loop and end
    function automatic logic [7:0] any_cmd();
        logic [2:0] grp;
        logic [3:0] low;
        grp = 3'($urandom_range(0, 7));
        low = 4'($urandom);
        if (grp == GRP_SYS && $urandom_range(0, 3) != 0) begin
            low = 4'hD + 4'($urandom_range(0, 2));
        end
        return cmd_byte(grp, low, 1'($urandom));
    endfunction

    // command with no payload, used to pad the frame to its exact length
    function automatic logic [7:0] filler_cmd();
        case ($urandom_range(0, 3))
            0:       return {CMD_EXTRA, 1'($urandom)};
            1:       return {CMD_END, 1'($urandom)};
            2:       return cmd_byte(GRP_SYS, 4'($urandom_range(0, 12)), 1'($urandom));
            default: return cmd_byte(GRP_MISC, 4'($urandom), 1'($urandom));
        endcase
    endfunction

    // build a frame body of random commands, then send it behind its size byte;
    // a cut frame gets a short size byte so a payload overruns or the stream slips
    task automatic send_frame(input bit cut);
        int         target;
        int         plen;
        logic [7:0] cmd;
        logic [7:0] size_byte;
        target = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 254) : $urandom_range(0, 30);
        frame_body.delete();
        while (frame_body.size() < target) begin
            cmd  = any_cmd();
            plen = payload_len_of(cmd);
            if (frame_body.size() + 1 + plen > target) begin
                cmd  = filler_cmd();
                plen = 0;
            end
            frame_body.push_back(cmd);
            repeat (plen) frame_body.push_back(payload_byte());
        end
        size_byte = 8'(frame_body.size() + 1);
        if (cut) begin
            size_byte = 8'($urandom_range(0, frame_body.size()));
        end
        push_byte(size_byte);
        foreach (frame_body[i]) push_byte(frame_body[i]);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_stream_byte = 8'h00;
        bytes_sent    = 0;
        idling_on     = 1'b1;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        push_byte(8'd0);                                   // size zero: overrun
        push_byte(8'd1);                                   // empty frame closes at once
        push_byte(8'd2); push_byte({CMD_EXTRA, 1'b0});     // extra result then normal close
        push_byte(8'd2); push_byte({CMD_END, 1'b1});       // end close
        // loop offset beats end, all-ones offset
        push_byte(8'd6); push_byte({CMD_LOOP, 1'b0});
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
        push_byte({CMD_END, 1'b0});
        // zero loop offset reads as no loop
        push_byte(8'd5); push_byte({CMD_LOOP, 1'b1});
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
        // single psg byte forwarded, then normal close
        push_byte(8'd3); push_byte(cmd_byte(GRP_PSG, 4'h0, 1'b0)); push_byte(8'hFF);
        // ym payload longer than the frame: overrun
        push_byte(8'd2); push_byte(cmd_byte(GRP_YM0, 4'h0, 1'b1));
        // unknown misc command has no effect
        push_byte(8'd2); push_byte(cmd_byte(GRP_MISC, 4'h5, 1'b1));

        // random part: mostly well-formed frames, some cut frames and raw noise
        while (bytes_sent < 1950) begin
            case ($urandom_range(0, 19))
                0, 1, 2: send_frame(1'b1);
                3, 4, 5: repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
                default: send_frame(1'b0);
            endcase
        end
        s_valid <= 1'b0;

        // drain everything still owed, then a short settle
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS music_frame_command_parser_unit");
        end else begin
            $display("FAIL music_frame_command_parser_unit");
        end
        $finish;
    end

endmodule

@@ music_frame_command_parser_unit.f @@
+incdir+rtl
rtl/mfcp_pkg.sv
rtl/mfcp_cmd_decode.sv
rtl/mfcp_result_queue.sv
rtl/music_frame_command_parser_unit.sv
bench/mfcp_stream_checker.sv
bench/tb_top.sv
